[rtl/core/thd_pkg.sv]
package thd_pkg;

  localparam int HarmCountDef = 10;
  localparam int FieldW = 16;
  localparam int NumW = 30;
  localparam logic [13:0] PctScale = 14'd10000;
  localparam logic [FieldW-1:0] PctMax = 16'hFFFF;
  localparam logic [31:0] SumMax = 32'hFFFF_FFFF;

  // One division in flight inside a divider cell chain.
  typedef struct packed {
    logic [NumW-1:0]   rem;
    logic [NumW-1:0]   num;
    logic [FieldW-1:0] den;
    logic [NumW-1:0]   quo;
  } div_t;

  // One square root in flight inside the root cell chain.
  typedef struct packed {
    logic [31:0]       val;
    logic [FieldW-1:0] root;
  } sqrt_t;

endpackage

[rtl/core/harmonic_thd_percent_core.sv]
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | fundamental, harm2..harm11
// out     | output    | out_valid / out_ready | pct2..pct11, thd_total
//
// One request enters every cycle while the output is not stalled. The pipeline is the numerator
// stage, the 30-cell restoring divider chain, one quotient bit per cell, the saturation stage,
// then the squaring adder stage and the 16-cell square-root chain.
// The whole pipeline advances only when the output register is empty or being taken,
// so a stalled output holds every stage in place and in_ready follows out_ready.
// Reset clears the valid bits only; payload registers are not reset.
module harmonic_thd_percent_core
  import thd_pkg::*;
#(
  parameter int HarmonicCount = HarmCountDef
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [FieldW-1:0] fundamental,
  input  logic [FieldW-1:0] harm2,
  input  logic [FieldW-1:0] harm3,
  input  logic [FieldW-1:0] harm4,
  input  logic [FieldW-1:0] harm5,
  input  logic [FieldW-1:0] harm6,
  input  logic [FieldW-1:0] harm7,
  input  logic [FieldW-1:0] harm8,
  input  logic [FieldW-1:0] harm9,
  input  logic [FieldW-1:0] harm10,
  input  logic [FieldW-1:0] harm11,
  output logic out_valid,
  input  logic out_ready,
  output logic [FieldW-1:0] pct2,
  output logic [FieldW-1:0] pct3,
  output logic [FieldW-1:0] pct4,
  output logic [FieldW-1:0] pct5,
  output logic [FieldW-1:0] pct6,
  output logic [FieldW-1:0] pct7,
  output logic [FieldW-1:0] pct8,
  output logic [FieldW-1:0] pct9,
  output logic [FieldW-1:0] pct10,
  output logic [FieldW-1:0] pct11,
  output logic [FieldW-1:0] thd_total
);

  localparam int HN = 10;
  localparam int Lat = NumW + 3 + FieldW;

  logic adv;
  logic [Lat-1:0] vld;
  logic [FieldW-1:0] harm_in [HN];

  // The pipeline moves as a whole whenever the last stage is free or drained.
  assign adv       = !vld[Lat-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[Lat-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Lat-2:0], in_valid};
    end
  end

  assign harm_in[0] = harm2;
  assign harm_in[1] = harm3;
  assign harm_in[2] = harm4;
  assign harm_in[3] = harm5;
  assign harm_in[4] = harm6;
  assign harm_in[5] = harm7;
  assign harm_in[6] = harm8;
  assign harm_in[7] = harm9;
  assign harm_in[8] = harm10;
  assign harm_in[9] = harm11;

  // Stage 0: form the rounded numerators, 10000*h + fund/2.
  div_t d0 [HN];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < HN; k++) begin
        d0[k].rem <= '0;
        d0[k].quo <= '0;
        d0[k].den <= fundamental;
        d0[k].num <= NumW'(harm_in[k]) * NumW'(PctScale) + NumW'(fundamental[FieldW-1:1]);
      end
    end
  end

  // Divider chains: one cell per quotient bit, one chain per harmonic lane.
  div_t dch [HN][NumW+1];
  logic [FieldW-1:0] pct [HN];

  for (genvar k = 0; k < HN; k++) begin : g_lane
    assign dch[k][0] = d0[k];
    for (genvar c = 0; c < NumW; c++) begin : g_cell
      thd_div_cell u_cell (.clk(clk), .en(adv), .din(dch[k][c]), .dout(dch[k][c+1]));
    end
  end

  // Stage: saturate quotients, zero for a zero fundamental; lanes beyond the
  // configured harmonic count read as zero.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < HN; k++) begin
        if (k >= HarmonicCount || dch[k][NumW].den == '0) begin
          pct[k] <= '0;
        end else if (|dch[k][NumW].quo[NumW-1:FieldW]) begin
          pct[k] <= PctMax;
        end else begin
          pct[k] <= dch[k][NumW].quo[FieldW-1:0];
        end
      end
    end
  end

  // Stage: squares and saturating sum. Ten squares of at most 2^32 fit in 36 bits.
  logic [FieldW-1:0] pct_d [HN];
  sqrt_t s0;
  logic [35:0] sum;
  always_comb begin
    sum = '0;
    for (int k = 0; k < HN; k++) begin
      sum = sum + {4'b0, 32'(pct[k]) * 32'(pct[k])};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pct_d   <= pct;
      s0.root <= '0;
      s0.val  <= (|sum[35:32]) ? SumMax : sum[31:0];
    end
  end

  // Square root chain: one cell per root bit, with the ratios riding alongside.
  sqrt_t sch [FieldW+1];
  logic [FieldW-1:0] pdel [FieldW+1][HN];
  assign sch[0]  = s0;
  assign pdel[0] = pct_d;

  for (genvar b = 0; b < FieldW; b++) begin : g_root
    thd_sqrt_cell #(.BitPos(FieldW-1-b)) u_cell (
      .clk(clk), .en(adv), .din(sch[b]), .dout(sch[b+1]));
    always_ff @(posedge clk) begin
      if (adv) begin
        pdel[b+1] <= pdel[b];
      end
    end
  end

  assign pct2      = pdel[FieldW][0];
  assign pct3      = pdel[FieldW][1];
  assign pct4      = pdel[FieldW][2];
  assign pct5      = pdel[FieldW][3];
  assign pct6      = pdel[FieldW][4];
  assign pct7      = pdel[FieldW][5];
  assign pct8      = pdel[FieldW][6];
  assign pct9      = pdel[FieldW][7];
  assign pct10     = pdel[FieldW][8];
  assign pct11     = pdel[FieldW][9];
  assign thd_total = sch[FieldW].root;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(thd_total) && $stable(pct2))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");
  a_root: assert property (@(posedge clk) disable iff (rst)
    out_valid && pct2 == '0 && pct3 == '0 && pct4 == '0 && pct5 == '0 && pct6 == '0
      && pct7 == '0 && pct8 == '0 && pct9 == '0 && pct10 == '0 && pct11 == '0
      |-> thd_total == '0)
    else $error("nonzero root for zero ratios");
`endif

endmodule

[rtl/core/thd_div_cell.sv]
module thd_div_cell
  import thd_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  div_t din,
  output div_t dout
);

  logic [NumW:0] trial;
  logic [NumW-1:0] shifted;

  // One restoring step: bring down the top numerator bit and try a subtract.
  always_comb begin
    shifted = {din.rem[NumW-2:0], din.num[NumW-1]};
    trial   = {1'b0, shifted} - {{(NumW+1-FieldW){1'b0}}, din.den};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.den <= din.den;
      dout.num <= {din.num[NumW-2:0], 1'b0};
      if (!trial[NumW]) begin
        dout.rem <= trial[NumW-1:0];
        dout.quo <= {din.quo[NumW-2:0], 1'b1};
      end else begin
        dout.rem <= shifted;
        dout.quo <= {din.quo[NumW-2:0], 1'b0};
      end
    end
  end

endmodule

[rtl/core/thd_sqrt_cell.sv]
module thd_sqrt_cell
  import thd_pkg::*;
#(
  parameter int BitPos = 15
) (
  input  logic  clk,
  input  logic  en,
  input  sqrt_t din,
  output sqrt_t dout
);

  logic [FieldW-1:0] cand;
  logic [31:0] sq;

  // Set this cell's root bit if the trial square still fits.
  always_comb begin
    cand = din.root | (FieldW'(1) << BitPos);
    sq   = 32'(cand) * 32'(cand);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.val  <= din.val;
      dout.root <= (sq <= din.val) ? cand : din.root;
    end
  end

endmodule

[tb/sv/tb_harmonic_thd_percent_core.sv]
`timescale 1ns / 1ps

// Self-checking bench for the harmonic ratio and total THD core.
module tb_harmonic_thd_percent_core;
  import thd_pkg::*;

  localparam int NumHarm = HarmCountDef;
  localparam int LatencyCycles = NumW + 3 + FieldW;
  localparam int RandomCount = 1100;
  localparam int WatchdogLimit = 20000;

  typedef logic [FieldW-1:0] field_t;

  // One request: the fundamental and the ten harmonic magnitudes.
  typedef struct {
    field_t fund;
    field_t harm [NumHarm];
  } thd_req_t;

  // One result: ten ratios and the total.
  typedef struct {
    field_t pct [NumHarm];
    field_t total;
  } thd_res_t;

  // A directed row, with a flag saying whether the expected value is typed in.
  typedef struct {
    thd_req_t req;
    bit       known;
    thd_res_t res;
  } thd_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  field_t fundamental = '0;
  field_t harm_in [NumHarm];
  logic out_valid;
  logic out_ready = 1'b0;
  field_t pct_out [NumHarm];
  field_t thd_total;

  thd_res_t pending_results [$];
  thd_res_t typed_results [$];
  bit typed_flags [$];
  int error_count = 0;
  int accepted_requests = 0;
  int checked_results = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  initial begin
    for (int i = 0; i < NumHarm; i++) begin
      harm_in[i] = '0;
    end
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  harmonic_thd_percent_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .fundamental(fundamental),
    .harm2      (harm_in[0]),
    .harm3      (harm_in[1]),
    .harm4      (harm_in[2]),
    .harm5      (harm_in[3]),
    .harm6      (harm_in[4]),
    .harm7      (harm_in[5]),
    .harm8      (harm_in[6]),
    .harm9      (harm_in[7]),
    .harm10     (harm_in[8]),
    .harm11     (harm_in[9]),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pct2       (pct_out[0]),
    .pct3       (pct_out[1]),
    .pct4       (pct_out[2]),
    .pct5       (pct_out[3]),
    .pct6       (pct_out[4]),
    .pct7       (pct_out[5]),
    .pct8       (pct_out[6]),
    .pct9       (pct_out[7]),
    .pct10      (pct_out[8]),
    .pct11      (pct_out[9]),
    .thd_total  (thd_total)
  );

  // Rounded ratio in hundredths of a percent, clamped to the field.
  function automatic field_t harm_ratio(field_t h, field_t f);
    logic [63:0] q;
    if (f == '0) begin
      return '0;
    end
    q = (64'd10000 * h + (f >> 1)) / f;
    return (q > 64'hFFFF) ? PctMax : q[FieldW-1:0];
  endfunction

  // Bitwise floor square root of a 32-bit value.
  function automatic field_t root_floor(logic [31:0] v);
    logic [15:0] r;
    logic [15:0] t;
    r = '0;
    for (int b = 15; b >= 0; b--) begin
      t = r | (16'd1 << b);
      if ({32'd0, t} * {32'd0, t} <= {32'd0, v}) begin
        r = t;
      end
    end
    return r;
  endfunction

  function automatic thd_res_t thd_of(thd_req_t r);
    thd_res_t res;
    logic [63:0] acc;
    acc = '0;
    for (int i = 0; i < NumHarm; i++) begin
      res.pct[i] = harm_ratio(r.harm[i], r.fund);
      acc += {48'd0, res.pct[i]} * {48'd0, res.pct[i]};
      if (acc > {32'd0, SumMax}) begin
        acc = {32'd0, SumMax};
      end
    end
    res.total = root_floor(acc[31:0]);
    return res;
  endfunction

  function automatic thd_req_t make_req(field_t f, field_t h);
    thd_req_t r;
    r.fund = f;
    for (int i = 0; i < NumHarm; i++) begin
      r.harm[i] = h;
    end
    return r;
  endfunction

  // Random request: fundamentals biased toward realistic sizes, with a few extremes.
  function automatic thd_req_t rand_req();
    thd_req_t r;
    int mode;
    mode = $urandom_range(0, 9);
    case (mode)
      0: r.fund = '0;
      1: r.fund = field_t'($urandom_range(1, 15));
      2, 3: r.fund = field_t'($urandom);
      default: r.fund = field_t'($urandom_range(1000, 65535));
    endcase
    for (int i = 0; i < NumHarm; i++) begin
      if (mode >= 4 && $urandom_range(0, 3) != 0) begin
        r.harm[i] = field_t'($urandom_range(0, 32'(r.fund) / 4));
      end else begin
        r.harm[i] = field_t'($urandom);
      end
    end
    return r;
  endfunction

  function automatic thd_res_t all_same(field_t p, field_t t);
    thd_res_t res;
    for (int i = 0; i < NumHarm; i++) begin
      res.pct[i] = p;
    end
    res.total = t;
    return res;
  endfunction

  task automatic send_req(thd_req_t r, bit known, thd_res_t typed);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
    end
    fundamental = r.fund;
    for (int i = 0; i < NumHarm; i++) begin
      harm_in[i] = r.harm[i];
    end
    in_valid = 1'b1;
    pending_results.push_back(thd_of(r));
    typed_flags.push_back(known);
    typed_results.push_back(typed);
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    accepted_requests++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // The receiver drops ready at random on every falling edge.
  always @(negedge clk) begin
    if (!rst) begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Results are checked at the rising edge where they are taken.
  always @(posedge clk) begin
    thd_res_t want;
    bit known;
    thd_res_t typed;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request outstanding", $time);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        known = typed_flags.pop_front();
        typed = typed_results.pop_front();
        if (known && (typed.pct != want.pct || typed.total != want.total)) begin
          $display("%0t: table row expected total %0d pct2 %0d, predictor %0d pct2 %0d",
                   $time, typed.total, typed.pct[0], want.total, want.pct[0]);
          error_count++;
        end
        for (int i = 0; i < NumHarm; i++) begin
          if (pct_out[i] !== want.pct[i]) begin
            $display("%0t: pct%0d expected %0d actual %0d", $time, i + 2,
                     want.pct[i], pct_out[i]);
            error_count++;
          end
        end
        if (thd_total !== want.total) begin
          $display("%0t: thd_total expected %0d actual %0d", $time, want.total,
                   thd_total);
          error_count++;
        end
        checked_results++;
      end
    end
  end

  // Watchdog on cycles with no request moving in either direction.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (!rst && idle_cycles >= WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    thd_row_t rows [$];
    thd_row_t row;
    thd_res_t none;
    none = all_same('0, '0);
    // Zero fundamental gives all zeros whatever the harmonics are.
    row.req = make_req('0, 16'hFFFF); row.known = 1; row.res = all_same('0, '0);
    rows.push_back(row);
    row.req = make_req('0, '0); row.known = 1; row.res = all_same('0, '0);
    rows.push_back(row);
    // Harmonics equal to the fundamental: 10000 each, total 31622; then zero harmonics.
    row.req = make_req(16'hFFFF, 16'hFFFF); row.known = 1;
    row.res = all_same(16'd10000, 16'd31622);
    rows.push_back(row);
    row.req = make_req(16'hFFFF, '0); row.known = 1; row.res = all_same('0, '0);
    rows.push_back(row);
    // Ratio saturates and the sum of squares clamps, so the total is 65535.
    row.req = make_req(16'd1, 16'hFFFF); row.known = 1;
    row.res = all_same(PctMax, 16'hFFFF);
    rows.push_back(row);
    row.req = make_req(16'd1, 16'd1); row.known = 1;
    row.res = all_same(16'd10000, 16'd31622);
    rows.push_back(row);
    // Half-up rounding around an odd fundamental, and ratios near the clamp.
    row.known = 0; row.res = none;
    row.req = make_req(16'd3, 16'd1); rows.push_back(row);
    row.req = make_req(16'd20000, 16'd1); rows.push_back(row);
    row.req = make_req(16'd20001, 16'd1); rows.push_back(row);
    row.req = make_req(16'd10000, 16'd65535); rows.push_back(row);
    row.req = make_req(16'd6, 16'd39); rows.push_back(row);
    row.req = make_req(16'd65534, 16'd32767); rows.push_back(row);
    row.req = make_req(16'h8000, 16'h5555); rows.push_back(row);
    row.req = make_req(16'h7FFF, 16'hAAAA); rows.push_back(row);
    // One large harmonic among small ones, and a walking bit pattern.
    row.req = make_req(16'd1000, '0); row.req.harm[9] = 16'd900; rows.push_back(row);
    row.req = make_req(16'd1000, '0); row.req.harm[0] = 16'd6553; rows.push_back(row);
    for (int i = 0; i < NumHarm; i++) begin
      row.req.harm[i] = field_t'(16'd1 << i);
    end
    row.req.fund = 16'd4096; rows.push_back(row);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[k]) begin
      send_req(rows[k].req, rows[k].known, rows[k].res);
    end
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 88 : 0;
      recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 15 : 0;
      for (int n = 0; n < RandomCount / 3; n++) begin
        send_req(rand_req(), 0, none);
      end
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (LatencyCycles + 10) @(posedge clk);
    $display("Sent %0d requests (directed table, then random under three stall mixes);",
             accepted_requests);
    $display("checked %0d results against the predictor.", checked_results);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
